>>> design/nse_pkg.sv
package nse_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_MAX_BODY = 2'd0;
  localparam logic [1:0] REG_GGA_SIG  = 2'd1;
  localparam logic [1:0] REG_RMC_SIG  = 2'd2;

  localparam logic [7:0]  MAX_BODY_RESET = 8'd87;
  localparam logic [10:0] GGA_SIG_RESET  = 11'd358;
  localparam logic [10:0] RMC_SIG_RESET  = 11'd377;

  localparam logic [7:0] DOLLAR_CHAR = 8'd36;
  localparam logic [7:0] CR_CHAR     = 8'd13;
  localparam logic [2:0] HEADER_LEN  = 3'd5;

  localparam logic [1:0] KIND_REJECT = 2'd0;
  localparam logic [1:0] KIND_GGA    = 2'd1;
  localparam logic [1:0] KIND_RMC    = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  max_body_length;
    logic [10:0] gga_signature;
    logic [10:0] rmc_signature;
  } cfg_t;

  typedef struct packed {
    logic [1:0] sentence_kind;
    logic [7:0] body_byte;
    logic       byte_valid;
    logic       last;
    logic       overflow;
  } result_t;

endpackage

>>> design/nse_cfg_regs.sv
module nse_cfg_regs
  import nse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_body_length <= MAX_BODY_RESET;
      cfg.gga_signature   <= GGA_SIG_RESET;
      cfg.rmc_signature   <= RMC_SIG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_BODY: cfg.max_body_length <= pwdata[7:0];
        REG_GGA_SIG:  cfg.gga_signature   <= pwdata[10:0];
        REG_RMC_SIG:  cfg.rmc_signature   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_BODY: prdata = {24'd0, cfg.max_body_length};
      REG_GGA_SIG:  prdata = {21'd0, cfg.gga_signature};
      REG_RMC_SIG:  prdata = {21'd0, cfg.rmc_signature};
      default:      prdata = '0;
    endcase
  end

endmodule

>>> design/nse_parser.sv
module nse_parser
  import nse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    res
);

  // input register
  logic       in_reg_valid;
  logic [7:0] in_byte;

  // parser state
  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [10:0] header_sum, header_sum_next;
  logic [1:0]  kind_found, kind_found_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  logic [7:0]  body_count, body_count_next;

  logic    out_free, proc, accept;
  logic    emit;
  result_t res_next;
  logic [10:0] sum_add;
  logic [2:0]  cnt_add;
  logic        cut;

  assign out_free = !out_valid || !out_stall;
  assign proc     = in_reg_valid && out_free;
  assign in_stall = in_reg_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (proc) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= rx_byte;
    end
  end

  assign sum_add = header_sum + {3'd0, in_byte};
  assign cnt_add = header_count + 3'd1;
  assign cut     = (in_byte == CR_CHAR) || (body_count >= cfg.max_body_length);

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    header_sum_next   = header_sum;
    kind_found_next   = kind_found;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    body_count_next   = body_count;
    emit              = 1'b0;
    res_next          = '0;
    case (phase)
      PH_HEADER: begin
        header_sum_next = sum_add;
        if (cnt_add < HEADER_LEN) begin
          header_count_next = cnt_add;
        end else begin
          header_count_next = 3'd0;
          if (sum_add == cfg.gga_signature || sum_add == cfg.rmc_signature) begin
            kind_found_next = (sum_add == cfg.gga_signature) ? KIND_GGA : KIND_RMC;
            phase_next      = PH_BODY;
            held_byte_next  = 8'd0;
            held_valid_next = 1'b0;
            body_count_next = 8'd0;
          end else begin
            phase_next             = PH_HUNT;
            emit                   = 1'b1;
            res_next.sentence_kind = KIND_REJECT;
            res_next.last          = 1'b1;
          end
        end
      end
      PH_BODY: begin
        if (cut) begin
          emit                   = 1'b1;
          res_next.sentence_kind = kind_found;
          res_next.body_byte     = held_valid ? held_byte : 8'd0;
          res_next.byte_valid    = held_valid;
          res_next.last          = 1'b1;
          res_next.overflow      = (in_byte != CR_CHAR);
          phase_next             = PH_HUNT;
          held_byte_next         = 8'd0;
          held_valid_next        = 1'b0;
          body_count_next        = 8'd0;
        end else begin
          emit                   = held_valid;
          res_next.sentence_kind = kind_found;
          res_next.body_byte     = held_byte;
          res_next.byte_valid    = 1'b1;
          held_byte_next         = in_byte;
          held_valid_next        = 1'b1;
          body_count_next        = body_count + 8'd1;
        end
      end
      default: begin
        // hunting; also recovers from the unused code
        phase_next = PH_HUNT;
        if (in_byte == DOLLAR_CHAR) begin
          phase_next        = PH_HEADER;
          header_count_next = 3'd0;
          header_sum_next   = 11'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      header_count <= 3'd0;
      header_sum   <= 11'd0;
      kind_found   <= KIND_REJECT;
      held_byte    <= 8'd0;
      held_valid   <= 1'b0;
      body_count   <= 8'd0;
    end else if (proc) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      header_sum   <= header_sum_next;
      kind_found   <= kind_found_next;
      held_byte    <= held_byte_next;
      held_valid   <= held_valid_next;
      body_count   <= body_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      res <= res_next;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.byte_valid |-> res.last)
    else $error("marker result without last");

  a_overflow_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.overflow |-> res.last && res.sentence_kind != KIND_REJECT)
    else $error("overflow on a non-final or rejected result");

  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.sentence_kind == KIND_REJECT |-> !res.byte_valid)
    else $error("rejection carries a body byte");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> header_count < HEADER_LEN)
    else $error("header count past header length");

  a_no_emit_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(res))
    else $error("result overwritten while stalled");

endmodule

>>> design/nmea_sentence_extractor.sv
// NMEA 0183 sentence extractor. Takes one received serial byte per transfer on
// the input channel (rx_byte) and hunts for '$'. The next five header bytes
// are summed and the sum is compared with gga_signature, then rmc_signature
// (GGA wins if both match). On a match every following byte up to CR goes out
// as a body byte tagged with the sentence kind; each body byte is held back by
// one byte so the final one carries last. A CR with no body gives an empty
// marker (byte_valid 0, last 1). An unknown header gives a single rejection
// result (kind 0, last 1). A body longer than max_body_length is cut off: the
// held byte goes out with last and overflow, and the hunt resumes. At most one
// result transfer follows each input transfer.
// Rate: one byte per clock sustained while the result channel is not stalled.
// A byte passes an input register, one level of parse logic and a result
// register; a stalled result register holds the byte in the input register.
// Input stall rises only while the input register is full and the result
// register is stalled.
// Registers (APB, byte address 4*index): 0x0 max_body_length (8b, reset 87),
// 0x4 gga_signature (11b, reset 358), 0x8 rmc_signature (11b, reset 377).
// Write them only while the block is idle.
module nmea_sentence_extractor
  import nse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // APB config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // byte input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            sentence_kind,
  output logic [7:0]            body_byte,
  output logic                  byte_valid,
  output logic                  last,
  output logic                  overflow
);

  cfg_t    cfg;
  result_t res;

  nse_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register -> parse logic -> result register
  nse_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign sentence_kind = res.sentence_kind;
  assign body_byte     = res.body_byte;
  assign byte_valid    = res.byte_valid;
  assign last          = res.last;
  assign overflow      = res.overflow;

endmodule

>>> verif/nmea_sentence_extractor_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the NMEA sentence extractor.
// Bytes go in one transfer at a time. A local parser model predicts every
// result, and a checker on the result channel compares each result transfer
// field by field with the oldest prediction.
module nmea_sentence_extractor_tb;
  import nse_pkg::*;

  localparam int QUIET_LIMIT     = 2000; // cycles with no transfer on either side
  localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall, fills the block
  localparam int SETTLE_CYCLES   = 4;    // two-stage pipe plus margin

  // DUT signals, all inputs known from time zero
  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte   = 8'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            sentence_kind;
  logic [7:0]            body_byte;
  logic                  byte_valid;
  logic                  last;
  logic                  overflow;

  nmea_sentence_extractor uut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Parser model: own copy of registers and state
  // ---------------------------------------------------------------------------
  cfg_t       cfg = '{MAX_BODY_RESET, GGA_SIG_RESET, RMC_SIG_RESET};
  phase_t     ph  = PH_HUNT;
  logic [2:0] hdr_count   = '0;
  logic [10:0] hdr_sum    = '0;
  logic [1:0] kind_seen   = KIND_REJECT;
  logic [7:0] held_byte   = '0;
  logic       held_valid  = 1'b0;
  logic [7:0] body_count  = '0;

  result_t expected_results[$];
  int      parsed_bytes = 0;  // bytes that were not just hunted over
  int      mismatches   = 0;

  // traffic shaping knobs
  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;
  int rx_hold_cycles = 0;

  function automatic result_t make_result(logic [1:0] k, logic [7:0] b, logic v,
                                          logic l, logic o);
    result_t r;
    r.sentence_kind = k;
    r.body_byte     = b;
    r.byte_valid    = v;
    r.last          = l;
    r.overflow      = o;
    return r;
  endfunction

  // Advance the model by one accepted byte; queue what it emits.
  task automatic parse_byte(input logic [7:0] b);
    if (ph != PH_HUNT || b == DOLLAR_CHAR) parsed_bytes++;
    case (ph)
      PH_HEADER: begin
        // '$' and CR are summed like any header byte
        hdr_sum   = hdr_sum + b;
        hdr_count = hdr_count + 3'd1;
        if (hdr_count == HEADER_LEN) begin
          hdr_count = '0;
          if (hdr_sum == cfg.gga_signature || hdr_sum == cfg.rmc_signature) begin
            // GGA wins when both signatures are equal
            kind_seen  = (hdr_sum == cfg.gga_signature) ? KIND_GGA : KIND_RMC;
            ph         = PH_BODY;
            held_byte  = '0;
            held_valid = 1'b0;
            body_count = '0;
          end else begin
            ph = PH_HUNT;
            expected_results.push_back(make_result(KIND_REJECT, 8'd0, 1'b0, 1'b1, 1'b0));
          end
        end
      end
      PH_BODY: begin
        if (b == CR_CHAR || body_count >= cfg.max_body_length) begin
          // CR closes the sentence; any other byte past the limit is dropped
          expected_results.push_back(make_result(kind_seen,
                                                 held_valid ? held_byte : 8'd0,
                                                 held_valid, 1'b1, b != CR_CHAR));
          ph         = PH_HUNT;
          held_byte  = '0;
          held_valid = 1'b0;
          body_count = '0;
        end else begin
          // one-byte delay so the final body byte can carry last
          if (held_valid)
            expected_results.push_back(make_result(kind_seen, held_byte, 1'b1, 1'b0, 1'b0));
          held_byte  = b;
          held_valid = 1'b1;
          body_count = body_count + 8'd1;
        end
      end
      default: begin
        ph        = (b == DOLLAR_CHAR) ? PH_HEADER : PH_HUNT;
        hdr_count = '0;
        hdr_sum   = '0;
      end
    endcase
  endtask

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    parse_byte(b);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Random body byte: mostly printable ('$' included), sometimes any byte but CR.
  function automatic logic [7:0] body_char();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 6) return 8'($urandom_range(32, 126));
    b = 8'($urandom_range(0, 255));
    return (b == CR_CHAR) ? ~b : b;
  endfunction

  // '$', five header bytes that add up to sig, body, optional CR.
  task automatic send_sentence(input logic [10:0] sig, input int body_len, input bit with_cr);
    int remaining, lo, hi;
    logic [7:0] hb;
    send_byte(DOLLAR_CHAR);
    remaining = sig;
    for (int i = 0; i < HEADER_LEN; i++) begin
      lo = remaining - 255 * (HEADER_LEN - 1 - i);
      if (lo < 0) lo = 0;
      hi = (remaining > 255) ? 255 : remaining;
      hb = 8'($urandom_range(hi, lo));
      send_byte(hb);
      remaining -= hb;
    end
    repeat (body_len) send_byte(body_char());
    if (with_cr) send_byte(CR_CHAR);
  endtask

  // Sender pause: input idle until every expected result has come, then let
  // the pipe settle (bytes that emit nothing may still be in flight).
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAX_BODY: cfg.max_body_length = value[7:0];
      REG_GGA_SIG:  cfg.gga_signature   = value[10:0];
      REG_RMC_SIG:  cfg.rmc_signature   = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_registers(input int max_len, input int gga, input int rmc);
    wait_idle();
    apb_write(REG_MAX_BODY, max_len);
    apb_write(REG_GGA_SIG, gga);
    apb_write(REG_RMC_SIG, rmc);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : result_stall_gen
    int n;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = stall_on ? pick_gap() : 0;
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d byte %0d", sentence_kind,
               body_byte);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("sentence_kind", want.sentence_kind, sentence_kind);
        check_field("body_byte", want.body_byte, body_byte);
        check_field("byte_valid", want.byte_valid, byte_valid);
        check_field("last", want.last, last);
        check_field("overflow", want.overflow, overflow);
      end
    end
  end

  // Watchdog: too long without any transfer means the run is stuck.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("nmea_sentence_extractor: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Byte extremes, GGA with '$' in the body, empty RMC, rejected header that
  // itself holds '$' and CR. Reset register values.
  task automatic test_directed_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$GPGGA$9");
    send_byte(CR_CHAR);
    send_text("$GPRMC");
    send_byte(CR_CHAR);
    send_byte(DOLLAR_CHAR);
    send_byte(DOLLAR_CHAR);
    send_byte(CR_CHAR);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // then the sender pauses until everything has drained.
  task automatic test_backpressure();
    wait_idle();
    idle_on = 1'b0;
    rx_hold_cycles = HOLD_OFF_CYCLES;
    repeat (3) send_sentence(cfg.gga_signature, 10, 1'b1);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Empty body, body exactly at the limit, one past it (cut off), one short.
  task automatic run_setting(input int max_len, input int gga, input int rmc);
    program_registers(max_len, gga, rmc);
    send_sentence(cfg.gga_signature, 0, 1'b1);
    send_sentence(cfg.rmc_signature, max_len, 1'b1);
    send_sentence(cfg.gga_signature, max_len + 1, 1'b1);
    send_sentence(cfg.rmc_signature, max_len - 1, 1'b1);
  endtask

  task automatic test_register_settings();
    run_setting(1, GGA_SIG_RESET, GGA_SIG_RESET);  // shortest body, equal signatures
    run_setting(255, 0, 1275);                     // longest body, signature extremes
    run_setting($urandom_range(2, 30), $urandom_range(0, 1275), $urandom_range(0, 1275));
  endtask

  // Mostly well-formed sentences with random content; the rest rejected
  // headers, truncated headers and raw noise.
  task automatic random_item();
    int r, r2, lim, len;
    r   = $urandom_range(0, 99);
    lim = cfg.max_body_length;
    if (r < 70) begin
      r2 = $urandom_range(0, 99);
      if (r2 < 80)      len = $urandom_range(0, (lim < 12) ? lim : 12);
      else if (r2 < 95) len = $urandom_range(lim + 2, (lim > 0) ? lim - 1 : 0);
      else              len = $urandom_range(0, lim + 3);
      send_sentence((r < 40) ? cfg.gga_signature : cfg.rmc_signature, len,
                    $urandom_range(0, 9) != 0);
    end else if (r < 82) begin
      send_sentence(11'($urandom_range(0, 1275)), 0, 1'($urandom_range(0, 1)));
    end else if (r < 92) begin
      send_byte(DOLLAR_CHAR);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    int r, max_len, gga, rmc, target;
    for (int round = 0; round < 4; round++) begin
      r = $urandom_range(0, 99);
      if (r < 20)      max_len = $urandom_range(1, 3);
      else if (r < 90) max_len = $urandom_range(4, 40);
      else             max_len = $urandom_range(41, 255);
      gga = $urandom_range(0, 1) ? GGA_SIG_RESET : $urandom_range(0, 1275);
      r   = $urandom_range(0, 9);
      rmc = (r < 5) ? RMC_SIG_RESET : (r < 7) ? gga : $urandom_range(0, 1275);
      program_registers(max_len, gga, rmc);
      // round 1 runs without any idling on either side
      idle_on  = (round != 1) && ($urandom_range(0, 3) != 0);
      stall_on = (round != 1) && ($urandom_range(0, 3) != 0);
      target = parsed_bytes + 110;
      while (parsed_bytes < target) random_item();
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_bytes();
    test_backpressure();
    test_register_settings();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("nmea_sentence_extractor: match");
    else
      $display("nmea_sentence_extractor: mismatch");
    $finish;
  end

endmodule
